/* rtl/core/fcst_pkg.sv */
// ----------------------------------------------------------------------------
// fcst_pkg: shared types and constants of the current sense transform
// Field widths, configuration register codes, the item and result records,
// current saturation and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package fcst_pkg;

  localparam int ADC_W     = 12;
  localparam int ANGLE_W   = 12;
  localparam int SCALE_W   = 24;
  localparam int POLES_W   = 8;
  localparam int CUR_W     = 16;
  localparam int BETA_W    = 17;
  localparam int DQ_W      = 18;
  localparam int TRIG_W    = 16;
  localparam int ROM_W     = TRIG_W - 1;
  localparam int QUARTER   = 1 << (ANGLE_W - 2);
  localparam int ADDR_W    = ANGLE_W - 1;

  // (code - bias) is ADC_W+1 signed, scale is SCALE_W+1 signed
  localparam int PROD_W    = ADC_W + SCALE_W + 2;
  localparam int SHR_W     = PROD_W - 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_W  = 40;
  localparam int OUT_W = 152;

  localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS    = 3'd0,
    CFG_SCALE   = 3'd1,
    CFG_ZERO    = 3'd2,
    CFG_POLES   = 3'd3,
    CFG_REVERSE = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [ADC_W-1:0]   bias;
    logic [SCALE_W-1:0] scale;
    logic [ANGLE_W-1:0] zero;
    logic [POLES_W-1:0] poles;
    logic               reverse;
  } fcst_cfg_t;

  // Queue entry between front and back
  typedef struct packed {
    logic signed [CUR_W-1:0]  iu;
    logic signed [CUR_W-1:0]  iw;
    logic signed [BETA_W-1:0] beta;
    logic [ANGLE_W-1:0]       ang;
  } fcst_item_t;

  // Result record, last field in the lowest bits
  typedef struct packed {
    logic signed [TRIG_W-1:0] cosine;
    logic signed [TRIG_W-1:0] sine;
    logic [ANGLE_W-1:0]       ang;
    logic signed [DQ_W-1:0]   q;
    logic signed [DQ_W-1:0]   d;
    logic signed [BETA_W-1:0] beta;
    logic signed [CUR_W-1:0]  alpha;
    logic signed [CUR_W-1:0]  iw;
    logic signed [CUR_W-1:0]  iu;
  } fcst_result_t;

  typedef logic [ROM_W-1:0] sine_rom_t [QUARTER+1];

  localparam longint HalfPiQ28 = 64'sd421657428;
  localparam longint OneQ28    = 64'sd268435456;
  localparam longint HalfQ28   = 64'sd134217728;
  localparam longint TaylorDiv [1:6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
                                         64'sd156};
  localparam longint Quarter   = longint'(QUARTER);

  function automatic logic signed [CUR_W-1:0] sat_current(input logic signed [SHR_W-1:0] v);
    logic signed [CUR_W-1:0] res;
    if (v > SHR_W'(32767)) begin
      res = 16'sh7fff;
    end else if (v < -SHR_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[CUR_W-1:0];
    end
    return res;
  endfunction

  // Q28 Taylor series, seven terms, truncating divisions; used at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    r;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (longint'(k) * HalfPiQ28) / Quarter;
      x2   = (x * x) >>> 28;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        term = -((term * x2) / OneQ28) / TaylorDiv[n];
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum * 64'sd32767 + HalfQ28) >>> 28;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
      rom[k] = r[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage

/* rtl/core/foc_current_sense_transform.sv */
// ----------------------------------------------------------------------------
// foc_current_sense_transform: phase current scaling, Clarke and Park
// Turns two phase-current ADC codes and a rotor angle into currents in
// 1/256 A, alpha/beta, d/q, the electrical angle and its sine and cosine.
//
// Usage:
// - Input stream (s_axis_*): one transfer per sample set. Output stream
//   (m_axis_*): one result transfer per input transfer, in order.
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at
//   the clock edge; indexes past the register list are dropped. Write only
//   while no sample is in flight.
// - Throughput: one transfer per clock while m_axis_tready_i stays high. Each
//   result passes through the 4 front stages, the queue and the 4 back stages
//   including the output register.
// - The queue between front and back (QUEUE_DEPTH entries) absorbs stalls:
//   when m_axis_tready_i drops, the back stages hold, the queue fills, and
//   s_axis_tready_o falls only once the queue and front stages are full.
// - Reset clears all valid flags and the queue and loads the register
//   defaults: bias 2048, scale 131072, zero 0, one pole pair, forward.
// ----------------------------------------------------------------------------
module foc_current_sense_transform import fcst_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: phase_u_code[11:0], phase_w_code[23:12], rotor_angle_code[35:24], zero pad
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: current_u[15:0], current_w[31:16], alpha_current[47:32],
  // beta_current[64:48], direct_current[82:65], quadrature_current[100:83],
  // electrical_angle[112:101], sine_value[128:113], cosine_value[144:129], zero pad
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  localparam int OUT_PAD = OUT_W - $bits(fcst_result_t);

  fcst_cfg_t    cfg_q;
  logic         fr_valid, fr_ready;
  fcst_item_t   fr_item;
  logic         bk_valid, bk_ready;
  fcst_item_t   bk_item;
  fcst_result_t res;

  // Register file; hold unless written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bias    <= ADC_W'(2048);
      cfg_q.scale   <= SCALE_W'(131072);
      cfg_q.zero    <= '0;
      cfg_q.poles   <= POLES_W'(1);
      cfg_q.reverse <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BIAS:    cfg_q.bias    <= cfg_data_i[ADC_W-1:0];
        CFG_SCALE:   cfg_q.scale   <= cfg_data_i[SCALE_W-1:0];
        CFG_ZERO:    cfg_q.zero    <= cfg_data_i[ANGLE_W-1:0];
        CFG_POLES:   cfg_q.poles   <= cfg_data_i[POLES_W-1:0];
        CFG_REVERSE: cfg_q.reverse <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: scale currents, beta, electrical angle
  fcst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .u_code_i     (s_axis_tdata_i[ADC_W-1:0]),
    .w_code_i     (s_axis_tdata_i[2*ADC_W-1:ADC_W]),
    .angle_i      (s_axis_tdata_i[2*ADC_W+ANGLE_W-1:2*ADC_W]),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  // Decouple front and back stalls
  fcst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  // Back: sine/cosine and Park rotation, output register
  fcst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = {OUT_PAD'(0), res};

endmodule

/* rtl/core/fcst_front.sv */
// ----------------------------------------------------------------------------
// fcst_front: current scaling, Clarke beta and electrical angle
// Four elastic stages: bias removal, scale multiply, shift and saturate,
// beta multiply. Each stage advances when the next one has room.
// ----------------------------------------------------------------------------
module fcst_front import fcst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcst_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ADC_W-1:0]   u_code_i,
  input  logic [ADC_W-1:0]   w_code_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output fcst_item_t         item_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [ADC_W:0]    du1_d, dw1_d, du1_q, dw1_q;
  logic [ANGLE_W-1:0]       ad1_d, ad1_q;
  logic signed [SCALE_W:0]  scale_s;
  logic signed [PROD_W-1:0] pu2_d, pw2_d, pu2_q, pw2_q;
  logic [ANGLE_W+POLES_W-1:0] ae_prod;
  logic [ANGLE_W-1:0]       ae2_q;
  logic signed [CUR_W-1:0]  iu3_d, iw3_d, iu3_q, iw3_q;
  logic [ANGLE_W-1:0]       ang3_d, ang3_q;
  logic signed [17:0]       bsum;
  logic signed [35:0]       bprod;
  fcst_item_t               item4_d, item4_q;

  assign rdy4 = !v4_q || item_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1;

  // Remove the amplifier bias, subtract the mechanical zero
  assign du1_d = $signed({1'b0, u_code_i}) - $signed({1'b0, cfg_i.bias});
  assign dw1_d = $signed({1'b0, w_code_i}) - $signed({1'b0, cfg_i.bias});
  assign ad1_d = angle_i - cfg_i.zero;

  // Scale and multiply by pole pairs
  assign scale_s = $signed({1'b0, cfg_i.scale});
  assign pu2_d   = PROD_W'(du1_q * scale_s);
  assign pw2_d   = PROD_W'(dw1_q * scale_s);
  assign ae_prod = ad1_q * cfg_i.poles;

  // Floor shift by 16 is the upper slice; saturate; apply direction
  assign iu3_d  = sat_current(pu2_q[PROD_W-1:16]);
  assign iw3_d  = sat_current(pw2_q[PROD_W-1:16]);
  assign ang3_d = cfg_i.reverse ? (ANGLE_W'(0) - ae2_q) : ae2_q;

  // Beta = (-iu - 2*iw) / sqrt(3), floor shift by 16
  assign bsum  = -18'(iu3_q) - (18'(iw3_q) <<< 1);
  assign bprod = bsum * INV_SQRT3_Q16;

  always_comb begin
    item4_d      = '0;
    item4_d.iu   = iu3_q;
    item4_d.iw   = iw3_q;
    item4_d.beta = bprod[32:16];
    item4_d.ang  = ang3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      du1_q <= du1_d;
      dw1_q <= dw1_d;
      ad1_q <= ad1_d;
    end
    if (rdy2) begin
      pu2_q <= pu2_d;
      pw2_q <= pw2_d;
      ae2_q <= ae_prod[ANGLE_W-1:0];
    end
    if (rdy3) begin
      iu3_q  <= iu3_d;
      iw3_q  <= iw3_d;
      ang3_q <= ang3_d;
    end
    if (rdy4) begin
      item4_q <= item4_d;
    end
  end

  assign item_valid_o = v4_q;
  assign item_o       = item4_q;

endmodule

/* rtl/core/fcst_queue.sv */
// ----------------------------------------------------------------------------
// fcst_queue: small FIFO between front and back
// Registered full and empty flags, so neither side sees the other's stall.
// ----------------------------------------------------------------------------
module fcst_queue import fcst_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  fcst_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output fcst_item_t pop_item_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  fcst_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

/* rtl/core/fcst_back.sv */
// ----------------------------------------------------------------------------
// fcst_back: sine/cosine lookup and Park rotation
// Four elastic stages: quarter-wave ROM read, quadrant signs, four products,
// floor shift and sum into the output register.
// ----------------------------------------------------------------------------
module fcst_back import fcst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  output logic         item_ready_o,
  input  fcst_item_t   item_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output fcst_result_t res_o
);

  localparam sine_rom_t SineRom = build_sine_rom();
  localparam logic [ADDR_W-1:0] QTR = ADDR_W'(QUARTER);
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [ADDR_W-1:0]        addr_a, addr_b;
  logic [ROM_W-1:0]         sa1_q, sb1_q;
  logic [1:0]               quad1_q;
  fcst_item_t               item1_q, item2_q, item3_q;
  logic signed [TRIG_W-1:0] sa, sb, s2_d, c2_d, s2_q, c2_q, s3_q, c3_q;
  logic signed [CUR_W:0]    niu;
  logic signed [31:0]       puc_q;
  logic signed [32:0]       pbs_q, pns_q, pbc_q;
  logic signed [DQ_W:0]     d_sum, q_sum;
  fcst_result_t             res_d, res_q;

  assign rdy4 = !v4_q || res_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign item_ready_o = rdy1;

  // Table addresses r and Q - r
  assign addr_a = {1'b0, item_i.ang[ANGLE_W-3:0]};
  assign addr_b = QTR - addr_a;

  // Quadrant symmetry
  assign sa = $signed({1'b0, sa1_q});
  assign sb = $signed({1'b0, sb1_q});

  always_comb begin
    case (quad1_q)
      QUAD_0: begin
        s2_d = sa;
        c2_d = sb;
      end
      QUAD_1: begin
        s2_d = sb;
        c2_d = -sa;
      end
      QUAD_2: begin
        s2_d = -sa;
        c2_d = -sb;
      end
      QUAD_3: begin
        s2_d = -sb;
        c2_d = sa;
      end
      default: begin
        s2_d = sa;
        c2_d = sb;
      end
    endcase
  end

  assign niu = -17'(item2_q.iu);

  // Floor shift by 15 is the upper slice of each product
  assign d_sum = 19'($signed(puc_q[31:15])) + 19'($signed(pbs_q[32:15]));
  assign q_sum = 19'($signed(pns_q[32:15])) + 19'($signed(pbc_q[32:15]));

  always_comb begin
    res_d        = '0;
    res_d.iu     = item3_q.iu;
    res_d.iw     = item3_q.iw;
    res_d.alpha  = item3_q.iu;
    res_d.beta   = item3_q.beta;
    res_d.d      = d_sum[DQ_W-1:0];
    res_d.q      = q_sum[DQ_W-1:0];
    res_d.ang    = item3_q.ang;
    res_d.sine   = s3_q;
    res_d.cosine = c3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= item_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sa1_q   <= SineRom[addr_a];
      sb1_q   <= SineRom[addr_b];
      quad1_q <= item_i.ang[ANGLE_W-1:ANGLE_W-2];
      item1_q <= item_i;
    end
    if (rdy2) begin
      s2_q    <= s2_d;
      c2_q    <= c2_d;
      item2_q <= item1_q;
    end
    if (rdy3) begin
      puc_q   <= item2_q.iu * c2_q;
      pbs_q   <= 33'(item2_q.beta * s2_q);
      pns_q   <= 33'(niu * s2_q);
      pbc_q   <= 33'(item2_q.beta * c2_q);
      s3_q    <= s2_q;
      c3_q    <= c2_q;
      item3_q <= item2_q;
    end
    if (rdy4) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = v4_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v4_q |-> (res_q.sine != 16'sh8000) && (res_q.cosine != 16'sh8000))
    else $error("sine or cosine outside Q1.15 table range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v4_q && (res_q.ang[ANGLE_W-3:0] == '0) |->
                   (res_q.sine == '0) || (res_q.cosine == '0))
    else $error("quadrant boundary without a zero sine or cosine");

endmodule
